FILE: rtl/sbsr_pkg.sv
// Package: shared types and constants of the servo bus status receiver.
package sbsr_pkg;

    localparam int SBSR_MAX_PARAMS = 64;

    localparam logic [7:0] BCAST_ID     = 8'd254;
    localparam logic [7:0] HDR_BYTE     = 8'hFF;
    localparam logic [7:0] MIN_LEN      = 8'd2;
    localparam logic [7:0] RESET_ID     = 8'd1;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic {
        KIND_PARAM  = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_ID    = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_ERR   = 6'b001000,
        PH_PARAM = 6'b010000,
        PH_SUM   = 6'b100000
    } t_phase;

endpackage

FILE: rtl/sbsr_ifs.sv
// Interfaces: input item, result item and configuration write channels.
interface sbsr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data;

    modport source (output valid, output operation, output data, input ready);
    modport sink   (input valid, input operation, input data, output ready);
endinterface

interface sbsr_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] status;
    logic [7:0] error_bits;
    logic [7:0] param_byte;
    logic [5:0] param_index;

    modport source (output valid, output kind, output status, output error_bits,
                    output param_byte, output param_index, input ready);
    modport sink   (input valid, input kind, input status, input error_bits,
                    input param_byte, input param_index, output ready);
endinterface

interface sbsr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/servo_bus_status_receiver.sv
// Top level: status reply parser for a half-duplex servo bus.
//
//  channel   | dir | payload                                            | transfer when
//  ----------+-----+----------------------------------------------------+--------------
//  i_cfg     | in  | data = expected_id                                 | valid & ready
//  i_item    | in  | operation, data                                    | valid & ready
//  o_result  | out | kind, status, error_bits, param_byte, param_index  | valid & ready
//
// Cycles: one item per cycle while the result slot is free or being taken; an input
//   transfer passes through the input register, then the parse logic into the result
//   register, from which the result transfers.
// Reset: synchronous, active low; expected_id returns to 1, the receiver idles.
// Stalls: a held result blocks the parse stage only; the input register still
//   takes one item while the result waits. Configuration is always ready.
module servo_bus_status_receiver
    import sbsr_pkg::*;
#(
    parameter int MAX_PARAMS = SBSR_MAX_PARAMS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sbsr_cfg_if.sink           i_cfg,
    sbsr_in_if.sink            i_item,
    sbsr_out_if.source         o_result
);

    // Longest legal length byte: error byte, parameters, checksum.
    localparam logic [8:0] LEN_MAX = 9'(MAX_PARAMS + 2);

    // Configuration register.
    logic [7:0] r_expected_id;

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_data;

    // Parser state.
    logic       r_armed,        n_armed;
    t_phase     r_phase,        n_phase;
    logic       r_header_one,   n_header_one;
    logic       r_got_any,      n_got_any;
    logic [7:0] r_packet_length, n_packet_length;
    logic [7:0] r_byte_count,   n_byte_count;
    logic [7:0] r_running_sum,  n_running_sum;
    logic [7:0] r_error_byte,   n_error_byte;

    // Result register.
    logic       r_out_valid;
    t_kind      r_kind,         n_kind;
    t_status    r_status,       n_status;
    logic [7:0] r_error_bits,   n_error_bits;
    logic [7:0] r_param_byte,   n_param_byte;
    logic [5:0] r_param_index,  n_param_index;
    logic       n_emit;

    logic       w_out_free;
    logic       w_fire;
    logic [8:0] w_param_end;

    // The parse stage advances when the result slot is free or being emptied.
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_fire       = r_in_valid && w_out_free;
    assign i_item.ready = !r_in_valid || w_fire;
    assign i_cfg.ready  = 1'b1;

    // Count after this parameter plus the error byte and checksum.
    assign w_param_end  = {1'b0, r_byte_count} + 9'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= RESET_ID;
        end else if (i_cfg.valid) begin
            r_expected_id <= i_cfg.data;
        end
    end

    // Input register: load on transfer, drop once parsed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op   <= i_item.operation;
            r_data <= i_item.data;
        end
    end

    // Parse one item against the current state.
    always_comb begin
        n_armed         = r_armed;
        n_phase         = r_phase;
        n_header_one    = r_header_one;
        n_got_any       = r_got_any;
        n_packet_length = r_packet_length;
        n_byte_count    = r_byte_count;
        n_running_sum   = r_running_sum;
        n_error_byte    = r_error_byte;
        n_emit          = 1'b0;
        n_kind          = KIND_STATUS;
        n_status        = ST_OK;
        n_error_bits    = 8'd0;
        n_param_byte    = 8'd0;
        n_param_index   = 6'd0;

        case (r_op)
            OP_START: begin
                // Drop any reception; broadcast ID reports OK, else hunt a header.
                n_phase         = PH_HUNT;
                n_header_one    = 1'b0;
                n_got_any       = 1'b0;
                n_packet_length = 8'd0;
                n_byte_count    = 8'd0;
                n_running_sum   = 8'd0;
                n_error_byte    = 8'd0;
                if (r_expected_id == BCAST_ID) begin
                    n_emit  = 1'b1;
                    n_armed = 1'b0;
                end else begin
                    n_armed = 1'b1;
                end
            end
            OP_BYTE: begin
                if (r_armed) begin
                    n_got_any = 1'b1;
                    unique case (r_phase)
                        PH_HUNT: begin
                            if (r_data == HDR_BYTE) begin
                                if (r_header_one) begin
                                    n_header_one = 1'b0;
                                    n_phase      = PH_ID;
                                end else begin
                                    n_header_one = 1'b1;
                                end
                            end else begin
                                n_header_one = 1'b0;
                            end
                        end
                        PH_ID: begin
                            if (r_data != r_expected_id) begin
                                n_emit   = 1'b1;
                                n_status = ST_CORRUPT;
                                n_armed  = 1'b0;
                            end else begin
                                n_running_sum = r_data;
                                n_phase       = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            if (r_data < MIN_LEN || {1'b0, r_data} > LEN_MAX) begin
                                n_emit   = 1'b1;
                                n_status = ST_CORRUPT;
                                n_armed  = 1'b0;
                            end else begin
                                n_packet_length = r_data;
                                n_running_sum   = r_running_sum + r_data;
                                n_phase         = PH_ERR;
                            end
                        end
                        PH_ERR: begin
                            n_error_byte  = r_data;
                            n_running_sum = r_running_sum + r_data;
                            n_byte_count  = 8'd0;
                            n_phase       = (r_packet_length > MIN_LEN) ? PH_PARAM : PH_SUM;
                        end
                        PH_PARAM: begin
                            n_emit        = 1'b1;
                            n_kind        = KIND_PARAM;
                            n_error_bits  = r_error_byte;
                            n_param_byte  = r_data;
                            n_param_index = r_byte_count[5:0];
                            n_running_sum = r_running_sum + r_data;
                            n_byte_count  = r_byte_count + 8'd1;
                            if (w_param_end >= {1'b0, r_packet_length}) begin
                                n_phase = PH_SUM;
                            end
                        end
                        PH_SUM: begin
                            n_emit  = 1'b1;
                            n_armed = 1'b0;
                            if (~r_running_sum == r_data) begin
                                n_error_bits = r_error_byte;
                            end else begin
                                n_status = ST_CORRUPT;
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
            end
            OP_TIMEOUT: begin
                if (r_armed) begin
                    n_emit   = 1'b1;
                    n_armed  = 1'b0;
                    n_status = r_got_any ? ST_CORRUPT : ST_TIMEOUT;
                end
            end
            default: begin
                // Unused operation code: no effect.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed         <= 1'b0;
            r_phase         <= PH_HUNT;
            r_header_one    <= 1'b0;
            r_got_any       <= 1'b0;
            r_packet_length <= 8'd0;
            r_byte_count    <= 8'd0;
            r_running_sum   <= 8'd0;
            r_error_byte    <= 8'd0;
        end else if (w_fire) begin
            r_armed         <= n_armed;
            r_phase         <= n_phase;
            r_header_one    <= n_header_one;
            r_got_any       <= n_got_any;
            r_packet_length <= n_packet_length;
            r_byte_count    <= n_byte_count;
            r_running_sum   <= n_running_sum;
            r_error_byte    <= n_error_byte;
        end
    end

    // Result register: load a new result, else clear after transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_kind        <= n_kind;
            r_status      <= n_status;
            r_error_bits  <= n_error_bits;
            r_param_byte  <= n_param_byte;
            r_param_index <= n_param_index;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.kind        = r_kind;
    assign o_result.status      = r_status;
    assign o_result.error_bits  = r_error_bits;
    assign o_result.param_byte  = r_param_byte;
    assign o_result.param_index = r_param_index;

    // A parameter result always carries a zero status.
    a_param_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_PARAM) |-> (r_status == ST_OK))
        else $error("parameter result with nonzero status");

    // A status result leaves the receiver idle.
    a_status_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_emit && n_kind == KIND_STATUS) |=> !r_armed)
        else $error("receiver still armed after status result");

    // Bytes and timeouts while idle give no result.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_armed && r_op != OP_START) |-> !n_emit)
        else $error("result produced while idle");

    // In the parameter phase at least one parameter is still due.
    a_param_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PARAM) |->
        (({1'b0, r_byte_count} + 9'd2) < {1'b0, r_packet_length}))
        else $error("parameter count overran packet length");

    // A full result slot that is not taken is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !w_fire)
        else $error("parse stage advanced into a held result");

endmodule

FILE: tb/tb_servo_bus_status_receiver.sv
`timescale 1ns / 1ps
// Testbench: directed table and random reply traffic for the servo bus status receiver.
module tb_servo_bus_status_receiver;
    import sbsr_pkg::*;

    // Operation code that the block has to ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Give up after this many cycles without any transfer on any channel.
    localparam int STALL_LIMIT = 2000;
    // Cycles from an input transfer until its result could show up, with margin.
    localparam int DRAIN_CYCLES = 6;
    localparam int N_PHASES = 7;

    // How a stimulus row is checked: against the predictor, as typed, or as silent.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_TYPED,
        CHK_QUIET
    } t_chk;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [7:0]  err;
        logic [7:0]  pbyte;
        logic [5:0]  pidx;
    } t_reply;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dat;
    } t_stim;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dat;
        t_chk       chk;
        t_reply     want;
    } t_row;

    localparam t_reply NO_REPLY      = '{KIND_PARAM, ST_OK, 8'h00, 8'h00, 6'd0};
    localparam t_reply REPLY_TIMEOUT = '{KIND_STATUS, ST_TIMEOUT, 8'h00, 8'h00, 6'd0};
    localparam t_reply REPLY_CORRUPT = '{KIND_STATUS, ST_CORRUPT, 8'h00, 8'h00, 6'd0};

    localparam int DIR_ROWS = 26;

    // Directed sequence, run with expected_id at its reset value of 1.
    localparam t_row DIRECTED [DIR_ROWS] = '{
        // bytes, timeouts and the unused code while idle: all dropped
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_TIMEOUT, 8'h00, CHK_QUIET, NO_REPLY},
        '{OP_UNUSED,  8'h5A, CHK_QUIET, NO_REPLY},
        // silent servo: timeout with nothing received
        '{OP_START,   8'h00, CHK_QUIET, NO_REPLY},
        '{OP_TIMEOUT, 8'h00, CHK_TYPED, REPLY_TIMEOUT},
        // a junk byte, then timeout: corrupt
        '{OP_START,   8'hA5, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'h00, CHK_QUIET, NO_REPLY},
        '{OP_TIMEOUT, 8'hFF, CHK_TYPED, REPLY_CORRUPT},
        // third 0xFF lands in the ID slot and mismatches
        '{OP_START,   8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_TYPED, REPLY_CORRUPT},
        // length below the minimum
        '{OP_START,   8'h00, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'h01, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'h01, CHK_TYPED, REPLY_CORRUPT},
        // start while armed, then a good one-parameter reply
        '{OP_START,   8'h00, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_START,   8'h00, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'hFF, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'h01, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'h03, CHK_QUIET, NO_REPLY},
        '{OP_BYTE,    8'h80, CHK_MODEL, NO_REPLY},
        '{OP_BYTE,    8'hAB, CHK_MODEL, NO_REPLY}
    };

    logic clk = 1'b0;
    logic rst_n;

    sbsr_cfg_if cfg_if ();
    sbsr_in_if  item_if ();
    sbsr_out_if res_if ();

    servo_bus_status_receiver dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_if),
        .i_item   (item_if),
        .o_result (res_if)
    );

    always #5 clk = ~clk;

    // Predictor state: our own copy of the receiver and its register.
    logic [7:0] exp_id;
    logic       rx_armed;
    t_phase     rx_phase;
    logic       hdr_seen;
    logic       saw_byte;
    logic [7:0] pkt_len;
    logic [7:0] param_cnt;
    logic [7:0] csum;
    logic [7:0] srv_err;

    t_reply pending_replies[$];
    t_stim  stim_q[$];

    // Check mode and typed result of the item currently on the input channel.
    t_chk   row_chk;
    t_reply row_want;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          fail_count;
    int          quiet_cycles;

    function automatic void clear_parser();
        rx_phase  = PH_HUNT;
        hdr_seen  = 1'b0;
        saw_byte  = 1'b0;
        pkt_len   = 8'h00;
        param_cnt = 8'h00;
        csum      = 8'h00;
        srv_err   = 8'h00;
    endfunction

    // Build a final status and drop back to idle.
    function automatic t_reply close_reply(input t_status st, input logic [7:0] err);
        t_reply r;
        r        = NO_REPLY;
        r.kind   = KIND_STATUS;
        r.status = st;
        r.err    = err;
        rx_armed = 1'b0;
        return r;
    endfunction

    // Advance the receiver by one input item; return 1 if it yields a result.
    function automatic bit parse_item(input logic [1:0] op, input logic [7:0] dat,
                                      output t_reply r);
        r = NO_REPLY;
        if (op == OP_START) begin
            clear_parser();
            if (exp_id == BCAST_ID) begin
                r = close_reply(ST_OK, 8'h00);
                return 1'b1;
            end
            rx_armed = 1'b1;
            return 1'b0;
        end
        if (!rx_armed) begin
            return 1'b0;
        end
        if (op == OP_TIMEOUT) begin
            r = close_reply(saw_byte ? ST_CORRUPT : ST_TIMEOUT, 8'h00);
            return 1'b1;
        end
        if (op != OP_BYTE) begin
            return 1'b0;
        end
        saw_byte = 1'b1;
        case (rx_phase)
            PH_HUNT: begin
                if (dat == HDR_BYTE) begin
                    if (hdr_seen) begin
                        hdr_seen = 1'b0;
                        rx_phase = PH_ID;
                    end else begin
                        hdr_seen = 1'b1;
                    end
                end else begin
                    hdr_seen = 1'b0;
                end
                return 1'b0;
            end
            PH_ID: begin
                if (dat != exp_id) begin
                    r = close_reply(ST_CORRUPT, 8'h00);
                    return 1'b1;
                end
                csum     = dat;
                rx_phase = PH_LEN;
                return 1'b0;
            end
            PH_LEN: begin
                if (dat < MIN_LEN || int'(dat) > SBSR_MAX_PARAMS + 2) begin
                    r = close_reply(ST_CORRUPT, 8'h00);
                    return 1'b1;
                end
                pkt_len  = dat;
                csum     = csum + dat;
                rx_phase = PH_ERR;
                return 1'b0;
            end
            PH_ERR: begin
                srv_err   = dat;
                csum      = csum + dat;
                param_cnt = 8'h00;
                if (pkt_len > MIN_LEN) begin
                    rx_phase = PH_PARAM;
                end else begin
                    rx_phase = PH_SUM;
                end
                return 1'b0;
            end
            PH_PARAM: begin
                r.kind    = KIND_PARAM;
                r.err     = srv_err;
                r.pbyte   = dat;
                r.pidx    = param_cnt[5:0];
                csum      = csum + dat;
                param_cnt = param_cnt + 8'd1;
                if (int'(param_cnt) + 2 >= int'(pkt_len)) begin
                    rx_phase = PH_SUM;
                end
                return 1'b1;
            end
            default: begin
                if (8'(~csum) == dat) begin
                    r = close_reply(ST_OK, srv_err);
                end else begin
                    r = close_reply(ST_CORRUPT, 8'h00);
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void add_stim(input logic [1:0] op, input logic [7:0] dat);
        t_stim s;
        s.op  = op;
        s.dat = dat;
        stim_q.push_back(s);
    endfunction

    // Queue one exchange: mostly a well-formed reply with random content,
    // sometimes noise, a silent servo, a bad field or a cut-off reply.
    function automatic void queue_exchange(input logic [7:0] id);
        logic [7:0]  body[$];
        logic [7:0]  len;
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned cut;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(6, 1)) add_stim(2'($urandom_range(3)), 8'($urandom));
            return;
        end
        add_stim(OP_START, 8'($urandom));
        if ($urandom_range(99) < 6) begin
            add_stim(OP_TIMEOUT, 8'($urandom));
            return;
        end
        // line noise ahead of the header
        if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(3, 1)) add_stim(OP_BYTE, 8'($urandom));
        end
        body.push_back(HDR_BYTE);
        body.push_back(HDR_BYTE);
        b = ($urandom_range(99) < 92) ? id : 8'($urandom);
        body.push_back(b);
        pick = $urandom_range(99);
        if (pick < 75) begin
            len = 8'($urandom_range(6, 2));
        end else if (pick < 88) begin
            len = 8'($urandom_range(SBSR_MAX_PARAMS + 1, 7));
        end else if (pick < 93) begin
            len = 8'(SBSR_MAX_PARAMS + 2);
        end else if (pick < 96) begin
            len = 8'($urandom_range(1));
        end else begin
            len = 8'($urandom_range(255, SBSR_MAX_PARAMS + 3));
        end
        body.push_back(len);
        sum = b + len;
        if (int'(len) <= SBSR_MAX_PARAMS + 2) begin
            b = 8'($urandom);
            body.push_back(b);
            sum = sum + b;
            for (int k = 2; k < int'(len); k++) begin
                b = 8'($urandom);
                body.push_back(b);
                sum = sum + b;
            end
            sum = ~sum;
            if ($urandom_range(99) < 10) begin
                sum = sum ^ 8'($urandom_range(255, 1));
            end
            body.push_back(sum);
        end
        if ($urandom_range(99) < 10) begin
            cut = $urandom_range(body.size() - 1);
            while (body.size() > cut) void'(body.pop_back());
            foreach (body[i]) add_stim(OP_BYTE, body[i]);
            add_stim(OP_TIMEOUT, 8'($urandom));
        end else begin
            foreach (body[i]) add_stim(OP_BYTE, body[i]);
        end
    endfunction

    // Present one item, with random sender idles ahead of it; return at the
    // falling edge after its transfer.
    task automatic drive_item(input logic [1:0] op, input logic [7:0] dat,
                              input t_chk chk, input t_reply want);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid     = 1'b1;
        item_if.operation = op;
        item_if.data      = dat;
        row_chk           = chk;
        row_want          = want;
        do @(posedge clk); while (!item_if.ready);
        @(negedge clk);
    endtask

    // Drop valid, drain the results, then let any silent item leave the pipeline.
    task automatic settle();
        item_if.valid = 1'b0;
        while (pending_replies.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_id(input logic [7:0] id);
        cfg_if.valid = 1'b1;
        cfg_if.data  = id;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Hold the sink ready pattern; a fresh draw every cycle.
    always @(negedge clk) begin
        res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on every input transfer, track register writes, check every result.
    always @(posedge clk) begin
        t_reply predicted;
        t_reply oldest;
        t_reply got;
        bit     has;
        if (!rst_n) begin
            clear_parser();
            rx_armed = 1'b0;
            exp_id   = RESET_ID;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                exp_id = cfg_if.data;
            end
            if (item_if.valid && item_if.ready) begin
                has = parse_item(item_if.operation, item_if.data, predicted);
                // typed rows override what the predictor says
                if (row_chk == CHK_TYPED) begin
                    has       = 1'b1;
                    predicted = row_want;
                end else if (row_chk == CHK_QUIET) begin
                    has = 1'b0;
                end
                if (has) begin
                    pending_replies.push_back(predicted);
                end
            end
            if (res_if.valid && res_if.ready) begin
                got.kind   = t_kind'(res_if.kind);
                got.status = t_status'(res_if.status);
                got.err    = res_if.error_bits;
                got.pbyte  = res_if.param_byte;
                got.pidx   = res_if.param_index;
                if (pending_replies.size() == 0) begin
                    $error("result with none expected: kind %0h status %0h",
                           got.kind, got.status);
                    fail_count++;
                end else begin
                    oldest = pending_replies.pop_front();
                    check_field("kind", 8'(oldest.kind), 8'(got.kind));
                    check_field("status", 8'(oldest.status), 8'(got.status));
                    check_field("error_bits", oldest.err, got.err);
                    check_field("param_byte", oldest.pbyte, got.pbyte);
                    check_field("param_index", 8'(oldest.pidx), 8'(got.pidx));
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_servo_bus_status_receiver NOT OK");
            $finish;
        end
    end

    initial begin
        logic [7:0]  phase_ids [N_PHASES];
        int unsigned phase_items [N_PHASES];
        logic [7:0]  cur_id;
        t_stim       s;
        // extremes first: zero, broadcast, all ones; then mid values, a random
        // ID and finally the reset value again
        phase_ids   = '{8'h00, BCAST_ID, 8'hFF, 8'h7F, 8'h80, 8'h00, RESET_ID};
        phase_items = '{220, 80, 220, 220, 220, 220, 220};

        rst_n             = 1'b0;
        item_if.valid     = 1'b0;
        item_if.operation = OP_START;
        item_if.data      = 8'h00;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = 8'h00;
        res_if.ready      = 1'b0;
        row_chk           = CHK_MODEL;
        row_want          = NO_REPLY;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        fail_count        = 0;
        quiet_cycles      = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table at the reset value of expected_id, no idling.
        foreach (DIRECTED[i]) begin
            drive_item(DIRECTED[i].op, DIRECTED[i].dat, DIRECTED[i].chk, DIRECTED[i].want);
        end
        // close the good reply with its checksum
        drive_item(OP_BYTE, 8'hD0, CHK_MODEL, NO_REPLY);

        // Random phases: new expected_id each time and a rotating idle pattern.
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            cur_id = (p == 5) ? 8'($urandom_range(253)) : phase_ids[p];
            write_id(cur_id);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            stim_q.delete();
            while (stim_q.size() < phase_items[p]) queue_exchange(cur_id);
            while (stim_q.size() != 0) begin
                s = stim_q.pop_front();
                drive_item(s.op, s.dat, CHK_MODEL, NO_REPLY);
            end
        end

        // Drain, then give stray results a chance to show up.
        item_if.valid  = 1'b0;
        recv_stall_pct = 0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_servo_bus_status_receiver OK");
        end else begin
            $display("tb_servo_bus_status_receiver NOT OK");
        end
        $finish;
    end

endmodule

FILE: servo_bus_status_receiver.f
rtl/sbsr_pkg.sv
rtl/sbsr_ifs.sv
rtl/servo_bus_status_receiver.sv
tb/tb_servo_bus_status_receiver.sv
